FILE: rtl/core/huffman_tree_bit_decoder_macros.svh
// Assertion macros used by the code tree decoder controller.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef HUFFMAN_TREE_BIT_DECODER_MACROS_SVH
`define HUFFMAN_TREE_BIT_DECODER_MACROS_SVH

// Plain property, checked outside reset
`define HTBD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication
`define HTBD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define HTBD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/htbd_pkg.sv
// Shared types and constants of the code tree decoder.
// No dependencies; imported by the controller and the top level.
`default_nettype none

package htbd_pkg;

	localparam int NODE_COUNT   = 512;
	localparam int MAX_CODE_LEN = 16;

	localparam int IDX_W      = $clog2(NODE_COUNT);
	localparam int CNT_W      = $clog2(NODE_COUNT + 1);
	localparam int CODE_W     = 16;
	localparam int CODE_IDX_W = $clog2(CODE_W);
	localparam int LEN_IN_W   = 5;
	localparam int LEN_SAT_W  = $clog2(MAX_CODE_LEN + 1);
	localparam int REM_W      = (LEN_SAT_W > LEN_IN_W) ? LEN_SAT_W : LEN_IN_W;
	localparam int SYM_W      = 8;
	localparam int STATUS_W   = 3;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_DECODE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_PENDING  = 3'd0,
		ST_SYMBOL   = 3'd1,
		ST_MISSING  = 3'd2,
		ST_INSERTED = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_CUR,
		S_RD_CHILD,
		S_INS_STEP,
		S_INS_LEAF,
		S_HOLD
	} state_t;

	// One node store word
	typedef struct packed {
		logic             leaf;
		logic [SYM_W-1:0] sym;
		logic [IDX_W-1:0] left;
		logic [IDX_W-1:0] right;
	} node_t;

	// Node store access from the controller
	typedef struct packed {
		logic             re;
		logic [IDX_W-1:0] raddr;
		logic             we;
		logic [IDX_W-1:0] waddr;
		node_t            wdata;
	} mem_req_t;

	typedef struct packed {
		status_t          status;
		logic [SYM_W-1:0] sym;
	} result_t;

endpackage

`default_nettype wire

FILE: rtl/core/htbd_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module htbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/htbd_ctrl.sv
// Tree walk controller: insert walks and decode steps over the node store.
// Depends on htbd_pkg and the assertion macro header.
`default_nettype none
`include "huffman_tree_bit_decoder_macros.svh"

module htbd_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              operation,
	input  logic                              bit_in,
	input  logic [htbd_pkg::SYM_W-1:0]        symbol,
	input  logic [htbd_pkg::CODE_W-1:0]       code_bits,
	input  logic [htbd_pkg::LEN_IN_W-1:0]     code_length,
	input  logic                              out_free,
	output logic                              res_valid,
	output htbd_pkg::result_t                 res,
	output htbd_pkg::mem_req_t                mem_req,
	input  htbd_pkg::node_t                   mem_rdata
);

	import htbd_pkg::*;

	state_t               state_q, state_d;
	logic [IDX_W-1:0]     cur_node_q, cur_node_d;
	logic                 cache_ok_q, cache_ok_d;
	logic [IDX_W-1:0]     cache_l_q, cache_l_d;
	logic [IDX_W-1:0]     cache_r_q, cache_r_d;
	logic                 root_ok_q, root_ok_d;
	logic [CNT_W-1:0]     nodes_used_q, nodes_used_d;
	logic [IDX_W-1:0]     node_q, node_d;
	logic                 zero_q, zero_d;
	logic [REM_W-1:0]     rem_q, rem_d;
	logic                 bit_q, bit_d;
	logic [SYM_W-1:0]     sym_q, sym_d;
	logic [CODE_W-1:0]    bits_q, bits_d;
	result_t              hold_q, hold_d;

	logic                 acc;
	node_t                entry;
	logic [REM_W-1:0]     pos;
	logic                 step_bit;
	logic [IDX_W-1:0]     slot;
	logic                 store_full;
	logic [IDX_W-1:0]     cache_child;
	logic [IDX_W-1:0]     rd_child;
	logic [REM_W-1:0]     len_ext;
	logic [REM_W-1:0]     len_sat;
	logic                 last_step;
	state_t               emit_state;
	result_t              r;
	logic                 fin;

	// Shared decisions on the current read data and inputs
	always_comb begin
		acc         = in_valid && in_ready;
		entry       = zero_q ? '0 : mem_rdata;
		pos         = rem_q - REM_W'(1);
		step_bit    = (pos < REM_W'(CODE_W)) ? bits_q[pos[CODE_IDX_W-1:0]] : 1'b0;
		slot        = step_bit ? entry.right : entry.left;
		store_full  = nodes_used_q >= CNT_W'(NODE_COUNT);
		cache_child = bit_in ? cache_r_q : cache_l_q;
		rd_child    = bit_q ? entry.right : entry.left;
		len_ext     = REM_W'(code_length);
		len_sat     = (len_ext > REM_W'(MAX_CODE_LEN)) ? REM_W'(MAX_CODE_LEN) : len_ext;
		last_step   = rem_q == REM_W'(1);
		emit_state  = out_free ? S_IDLE : S_HOLD;
	end

	assign in_ready = state_q == S_IDLE;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					if (operation == OP_DECODE) begin
						if (cache_ok_q) begin
							state_d = (cache_child == '0) ? emit_state : S_RD_CHILD;
						end else begin
							state_d = S_RD_CUR;
						end
					end else begin
						state_d = (code_length == '0) ? emit_state : S_INS_STEP;
					end
				end
			end
			S_RD_CUR:   state_d = (rd_child == '0) ? emit_state : S_RD_CHILD;
			S_RD_CHILD: state_d = emit_state;
			S_INS_STEP: begin
				if (slot == '0 && store_full) begin
					state_d = emit_state;
				end else if (last_step) begin
					state_d = S_INS_LEAF;
				end
			end
			S_INS_LEAF: state_d = emit_state;
			S_HOLD:     state_d = out_free ? S_IDLE : S_HOLD;
			default:    state_d = S_IDLE;
		endcase
	end

	// Memory requests, results and register updates
	always_comb begin
		node_t            w;
		logic [IDX_W-1:0] nxt;
		logic             fresh;
		w            = entry;
		nxt          = slot;
		fresh        = 1'b0;
		mem_req      = '0;
		fin          = 1'b0;
		r            = '{status: ST_PENDING, sym: '0};
		res_valid    = 1'b0;
		res          = '{status: ST_PENDING, sym: '0};
		cur_node_d   = cur_node_q;
		cache_ok_d   = cache_ok_q;
		cache_l_d    = cache_l_q;
		cache_r_d    = cache_r_q;
		root_ok_d    = root_ok_q;
		nodes_used_d = nodes_used_q;
		node_d       = node_q;
		zero_d       = zero_q;
		rem_d        = rem_q;
		bit_d        = bit_q;
		sym_d        = sym_q;
		bits_d       = bits_q;
		hold_d       = hold_q;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					if (operation == OP_DECODE) begin
						bit_d = bit_in;
						if (cache_ok_q) begin
							if (cache_child == '0) begin
								fin        = 1'b1;
								r.status   = ST_MISSING;
								cur_node_d = '0;
								cache_ok_d = 1'b0;
							end else begin
								mem_req.re    = 1'b1;
								mem_req.raddr = cache_child;
								node_d        = cache_child;
								zero_d        = 1'b0;
							end
						end else begin
							mem_req.re    = 1'b1;
							mem_req.raddr = cur_node_q;
							node_d        = cur_node_q;
							zero_d        = (cur_node_q == '0) && !root_ok_q;
						end
					end else begin
						// Inserts may rewrite the cached node
						cache_ok_d = 1'b0;
						sym_d      = symbol;
						bits_d     = code_bits;
						if (code_length == '0) begin
							fin      = 1'b1;
							r.status = ST_MISSING;
						end else begin
							rem_d         = len_sat;
							mem_req.re    = 1'b1;
							mem_req.raddr = '0;
							node_d        = '0;
							zero_d        = !root_ok_q;
						end
					end
				end
			end
			S_RD_CUR: begin
				cache_l_d  = entry.left;
				cache_r_d  = entry.right;
				cache_ok_d = 1'b1;
				if (rd_child == '0) begin
					fin        = 1'b1;
					r.status   = ST_MISSING;
					cur_node_d = '0;
					cache_ok_d = 1'b0;
				end else begin
					mem_req.re    = 1'b1;
					mem_req.raddr = rd_child;
					node_d        = rd_child;
					zero_d        = 1'b0;
				end
			end
			S_RD_CHILD: begin
				fin = 1'b1;
				if (entry.leaf) begin
					r.status   = ST_SYMBOL;
					r.sym      = entry.sym;
					cur_node_d = '0;
					cache_ok_d = 1'b0;
				end else begin
					r.status   = ST_PENDING;
					cur_node_d = node_q;
					cache_l_d  = entry.left;
					cache_r_d  = entry.right;
					cache_ok_d = 1'b1;
				end
			end
			S_INS_STEP: begin
				// Write back every visited node so a fresh one is initialised
				mem_req.we    = 1'b1;
				mem_req.waddr = node_q;
				if (slot == '0 && store_full) begin
					mem_req.wdata = entry;
					fin           = 1'b1;
					r.status      = ST_FULL;
				end else begin
					if (slot == '0) begin
						nxt          = nodes_used_q[IDX_W-1:0];
						fresh        = 1'b1;
						nodes_used_d = nodes_used_q + CNT_W'(1);
						if (step_bit) begin
							w.right = nxt;
						end else begin
							w.left = nxt;
						end
					end
					mem_req.wdata = w;
					mem_req.re    = 1'b1;
					mem_req.raddr = nxt;
					node_d        = nxt;
					zero_d        = fresh;
					rem_d         = rem_q - REM_W'(1);
				end
			end
			S_INS_LEAF: begin
				w.leaf        = 1'b1;
				w.sym         = sym_q;
				mem_req.we    = 1'b1;
				mem_req.waddr = node_q;
				mem_req.wdata = w;
				fin           = 1'b1;
				r.status      = ST_INSERTED;
			end
			S_HOLD: begin
				if (out_free) begin
					res_valid = 1'b1;
					res       = hold_q;
				end
			end
			default: begin
				mem_req = '0;
			end
		endcase
		// Hand over the result, or park it until the output frees
		if (fin) begin
			if (out_free) begin
				res_valid = 1'b1;
				res       = r;
			end else begin
				hold_d = r;
			end
		end
		if (mem_req.we && mem_req.waddr == '0) begin
			root_ok_d = 1'b1;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cur_node_q   <= '0;
			cache_ok_q   <= 1'b1;
			cache_l_q    <= '0;
			cache_r_q    <= '0;
			root_ok_q    <= 1'b0;
			nodes_used_q <= CNT_W'(1);
		end else begin
			state_q      <= state_d;
			cur_node_q   <= cur_node_d;
			cache_ok_q   <= cache_ok_d;
			cache_l_q    <= cache_l_d;
			cache_r_q    <= cache_r_d;
			root_ok_q    <= root_ok_d;
			nodes_used_q <= nodes_used_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		node_q <= node_d;
		zero_q <= zero_d;
		rem_q  <= rem_d;
		bit_q  <= bit_d;
		sym_q  <= sym_d;
		bits_q <= bits_d;
		hold_q <= hold_d;
	end

	`HTBD_ASSERT_IMP(a_rw_apart, mem_req.we && mem_req.re, mem_req.waddr != mem_req.raddr, "node store read and write on the same entry")
	`HTBD_ASSERT_IMP(a_emit_free, res_valid, out_free, "result issued while output register occupied")
	`HTBD_ASSERT(a_alloc_step, (nodes_used_q == $past(nodes_used_q)) || ($past(state_q) == S_INS_STEP), "node count moved outside an insert step")
	`HTBD_ASSERT_NXT(a_ins_drops_cache, acc && (operation == OP_INSERT), !cache_ok_q, "insert left the child cache valid")

endmodule

`default_nettype wire

FILE: rtl/core/huffman_tree_bit_decoder.sv
// Code tree decoder top level: node store, walk controller, output register.
// Depends on htbd_pkg, htbd_ram and htbd_ctrl.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one item per transfer: operation 0
//   inserts a code (symbol, code_bits MSB first, code_length), operation 1
//   decodes one bit_in. Output channel (out_valid/out_ready) returns exactly
//   one status/symbol_out per item, in order.
//   An insert does one node store read-modify-write per code bit (length
//   capped at 16) plus the leaf write, and stops early when the store is full;
//   a zero length needs no node store access. A decode step mid-code reads
//   only the child's word, as the current node's children sit in a register;
//   after returning to the root or after an insert it reads the current node
//   first, then the child unless that read finds no branch; a missing cached
//   branch needs no read. The result reaches out_valid in the same cycle as
//   the next item can be taken. Reset sets the node count to one and clears
//   the walk position and the root valid flag at once; no clearing pass, as
//   every other node is written when first visited. A stalled receiver holds
//   the result in the output register; one more item is taken and its result
//   parks until the register frees.
`default_nettype none

module huffman_tree_bit_decoder (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              operation,
	input  logic                              bit_in,
	input  logic [htbd_pkg::SYM_W-1:0]        symbol,
	input  logic [htbd_pkg::CODE_W-1:0]       code_bits,
	input  logic [htbd_pkg::LEN_IN_W-1:0]     code_length,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [htbd_pkg::STATUS_W-1:0]     status,
	output logic [htbd_pkg::SYM_W-1:0]        symbol_out
);

	import htbd_pkg::*;

	mem_req_t                mem_req;
	node_t                   mem_rdata;
	logic [$bits(node_t)-1:0] ram_rdata;
	logic                    out_free;
	logic                    res_valid;
	result_t                 res;
	logic                    out_valid_q;
	status_t                 out_status_q;
	logic [SYM_W-1:0]        out_sym_q;

	assign mem_rdata = node_t'(ram_rdata);

	htbd_ram #(
		.WIDTH ($bits(node_t)),
		.DEPTH (NODE_COUNT)
	) u_node_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (ram_rdata)
	);

	htbd_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.bit_in      (bit_in),
		.symbol      (symbol),
		.code_bits   (code_bits),
		.code_length (code_length),
		.out_free    (out_free),
		.res_valid   (res_valid),
		.res         (res),
		.mem_req     (mem_req),
		.mem_rdata   (mem_rdata)
	);

	// Output register frees on a transfer or when empty
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the result payload
	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_status_q <= res.status;
			out_sym_q    <= res.sym;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign symbol_out = out_sym_q;

endmodule

`default_nettype wire
